// File: design/crp_pkg.sv
// Shared types and constants for the camera request parser.
package crp_pkg;

    localparam logic [7:0] MAGIC_0        = 8'hCA;
    localparam logic [7:0] MAGIC_1        = 8'hFE;
    localparam logic [7:0] VERSION_OK     = 8'h01;
    localparam logic [3:0] BYTE_COUNT_MIN = 4'd10;
    localparam logic [2:0] LAST_INT_INDEX = 3'd6;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [3:0] KIND_NONE = 4'd0;
    localparam logic [3:0] KIND_CAM  = 4'd8;
    localparam logic [3:0] KIND_IP   = 4'd9;

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_VERSION,
        PH_INTS,
        PH_CAMLEN,
        PH_CAMCHR,
        PH_IPLEN,
        PH_IPCHR,
        PH_DONE,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_MAGIC,
        ST_VERSION,
        ST_INTS,
        ST_STRLEN,
        ST_STRING
    } t_status;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]         field_kind;
        logic signed [31:0] field_value;
        logic               finished;
        logic [2:0]         status;
    } t_out;

endpackage

// File: design/crp_front.sv
// Front end: takes request bytes, tracks the parse phase and builds result beats.
module crp_front
    import crp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    input  logic i_full,
    output logic o_push,
    output t_out o_item
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [23:0] r_word, n_word;
    logic [1:0]  r_biw, n_biw;
    logic [2:0]  r_fidx, n_fidx;
    logic [7:0]  r_rem, n_rem;
    t_status     r_err, n_err;

    logic        accept;
    logic        have;
    logic [3:0]  kind;
    logic [31:0] value;
    t_status     status;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (have || i_in.last_byte);

    // next state of the parse
    always_comb begin
        n_phase = r_phase;
        n_cnt   = (r_cnt < BYTE_COUNT_MIN) ? r_cnt + 4'd1 : r_cnt;
        n_word  = r_word;
        n_biw   = r_biw;
        n_fidx  = r_fidx;
        n_rem   = r_rem;
        n_err   = r_err;
        unique case (r_phase)
            PH_MAGIC0: begin
                if (i_in.byte_in == MAGIC_0) begin
                    n_phase = PH_MAGIC1;
                end else begin
                    n_err   = ST_MAGIC;
                    n_phase = PH_HALT;
                end
            end
            PH_MAGIC1: begin
                if (i_in.byte_in == MAGIC_1) begin
                    n_phase = PH_VERSION;
                end else begin
                    n_err   = ST_MAGIC;
                    n_phase = PH_HALT;
                end
            end
            PH_VERSION: begin
                if (i_in.byte_in == VERSION_OK) begin
                    n_phase = PH_INTS;
                end else begin
                    n_err   = ST_VERSION;
                    n_phase = PH_HALT;
                end
            end
            PH_INTS: begin
                n_word = {i_in.byte_in, r_word[23:8]};
                n_biw  = r_biw + 2'd1;
                if (r_biw == 2'd3) begin
                    if (r_fidx >= LAST_INT_INDEX) begin
                        n_fidx  = '0;
                        n_phase = PH_CAMLEN;
                    end else begin
                        n_fidx = r_fidx + 3'd1;
                    end
                end
            end
            PH_CAMLEN: begin
                n_rem   = i_in.byte_in;
                n_phase = (i_in.byte_in == 8'd0) ? PH_IPLEN : PH_CAMCHR;
            end
            PH_CAMCHR: begin
                n_rem = r_rem - 8'd1;
                if (r_rem == 8'd1) begin
                    n_phase = PH_IPLEN;
                end
            end
            PH_IPLEN: begin
                n_rem   = i_in.byte_in;
                n_phase = (i_in.byte_in == 8'd0) ? PH_DONE : PH_IPCHR;
            end
            PH_IPCHR: begin
                n_rem = r_rem - 8'd1;
                if (r_rem == 8'd1) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // result beat for this byte
    always_comb begin
        have  = 1'b0;
        kind  = KIND_NONE;
        value = '0;
        unique case (r_phase)
            PH_INTS: begin
                if (r_biw == 2'd3) begin
                    have  = 1'b1;
                    kind  = {1'b0, r_fidx} + 4'd1;
                    value = {i_in.byte_in, r_word};
                end
            end
            PH_CAMCHR: begin
                have  = 1'b1;
                kind  = KIND_CAM;
                value = {24'd0, i_in.byte_in};
            end
            PH_IPCHR: begin
                have  = 1'b1;
                kind  = KIND_IP;
                value = {24'd0, i_in.byte_in};
            end
            default: begin
            end
        endcase

        if (n_cnt < BYTE_COUNT_MIN) begin
            status = ST_SHORT;
        end else if (n_err != ST_OK) begin
            status = n_err;
        end else begin
            unique case (n_phase)
                PH_INTS:             status = ST_INTS;
                PH_CAMLEN, PH_IPLEN: status = ST_STRLEN;
                PH_CAMCHR, PH_IPCHR: status = ST_STRING;
                PH_DONE:             status = ST_OK;
                default:             status = ST_SHORT;
            endcase
        end

        o_item.field_kind  = kind;
        o_item.field_value = value;
        o_item.finished    = i_in.last_byte;
        o_item.status      = i_in.last_byte ? status : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC0;
            r_cnt   <= '0;
            r_word  <= '0;
            r_biw   <= '0;
            r_fidx  <= '0;
            r_rem   <= '0;
            r_err   <= ST_OK;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_phase <= PH_MAGIC0;
                r_cnt   <= '0;
                r_word  <= '0;
                r_biw   <= '0;
                r_fidx  <= '0;
                r_rem   <= '0;
                r_err   <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_word  <= n_word;
                r_biw   <= n_biw;
                r_fidx  <= n_fidx;
                r_rem   <= n_rem;
                r_err   <= n_err;
            end
        end
    end

endmodule

// File: design/crp_fifo.sv
// Back end: short result queue that drives the output channel.
module crp_fifo
    import crp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_out               i_item,
    output logic               o_full,
    output logic [FIFO_AW:0]   o_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out
);

    t_out               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count, n_count;
    logic               pop;

    assign o_full      = (r_count == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_count     = r_count;
    assign o_out_valid = (r_count != '0);
    assign o_out       = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: design/camera_request_parser_top.sv
// Camera request parser: byte-serial front end feeding a result queue.
// Output: each result beat is registered in the queue before it is offered.
// Throughput: one byte per cycle; input stalls only while the 4-beat queue is full,
// which the output side's ready sets.
// Reset: synchronous, active low; clears parse state and empties the queue.
module camera_request_parser_top
    import crp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic             push;
    logic             full;
    logic [FIFO_AW:0] count;
    t_out             item;

    crp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_item     (item)
    );

    crp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (item),
        .o_full      (full),
        .o_count     (count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue overflow");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> count == (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("input stalled with queue space");

    a_status_unfinished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.finished |-> o_out.status == ST_OK)
        else $error("status set on a provisional beat");

    a_none_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.field_kind == KIND_NONE |-> o_out.finished)
        else $error("empty beat before the last byte");

endmodule

// File: test/camera_request_parser_top_tb.sv
// Testbench for camera_request_parser_top: byte-serial requests checked against a parse predictor.
`timescale 1ns / 100ps

module camera_request_parser_top_tb;
    import crp_pkg::*;

    class request_scoreboard;
        t_phase     phase;
        logic [3:0] nbytes;
        logic [31:0] word;
        logic [1:0] word_pos;
        logic [2:0] int_idx;
        logic [7:0] str_left;
        t_status    err;
        t_out       expected_fields[$];
        int         errors;

        function void clear();
            phase    = PH_MAGIC0;
            nbytes   = '0;
            word     = '0;
            word_pos = '0;
            int_idx  = '0;
            str_left = '0;
            err      = ST_OK;
        endfunction

        function t_status final_status();
            if (nbytes < BYTE_COUNT_MIN) return ST_SHORT;
            if (err != ST_OK) return err;
            case (phase)
                PH_INTS:             return ST_INTS;
                PH_CAMLEN, PH_IPLEN: return ST_STRLEN;
                PH_CAMCHR, PH_IPCHR: return ST_STRING;
                PH_DONE:             return ST_OK;
                default:             return ST_SHORT;
            endcase
        endfunction

        function void note_byte(t_in b);
            logic have;
            t_out r;
            have = 1'b0;
            r    = '0;
            if (nbytes < BYTE_COUNT_MIN) nbytes++;
            case (phase)
                PH_MAGIC0: begin
                    if (b.byte_in == MAGIC_0) phase = PH_MAGIC1;
                    else begin
                        err   = ST_MAGIC;
                        phase = PH_HALT;
                    end
                end
                PH_MAGIC1: begin
                    if (b.byte_in == MAGIC_1) phase = PH_VERSION;
                    else begin
                        err   = ST_MAGIC;
                        phase = PH_HALT;
                    end
                end
                PH_VERSION: begin
                    if (b.byte_in == VERSION_OK) phase = PH_INTS;
                    else begin
                        err   = ST_VERSION;
                        phase = PH_HALT;
                    end
                end
                PH_INTS: begin
                    word = word | (32'(b.byte_in) << (8 * word_pos));
                    if (word_pos == 2'd3) begin
                        have          = 1'b1;
                        r.field_kind  = 4'(int_idx) + 4'd1;
                        r.field_value = word;
                        word          = '0;
                        word_pos      = '0;
                        if (int_idx >= LAST_INT_INDEX) begin
                            int_idx = '0;
                            phase   = PH_CAMLEN;
                        end else begin
                            int_idx++;
                        end
                    end else begin
                        word_pos++;
                    end
                end
                PH_CAMLEN: begin
                    str_left = b.byte_in;
                    phase    = (b.byte_in == 8'd0) ? PH_IPLEN : PH_CAMCHR;
                end
                PH_CAMCHR: begin
                    have          = 1'b1;
                    r.field_kind  = KIND_CAM;
                    r.field_value = 32'(b.byte_in);
                    str_left--;
                    if (str_left == 8'd0) phase = PH_IPLEN;
                end
                PH_IPLEN: begin
                    str_left = b.byte_in;
                    phase    = (b.byte_in == 8'd0) ? PH_DONE : PH_IPCHR;
                end
                PH_IPCHR: begin
                    have          = 1'b1;
                    r.field_kind  = KIND_IP;
                    r.field_value = 32'(b.byte_in);
                    str_left--;
                    if (str_left == 8'd0) phase = PH_DONE;
                end
                default: ;
            endcase
            if (!have && !b.last_byte) return;
            if (b.last_byte) begin
                r.finished = 1'b1;
                r.status   = final_status();
                clear();
            end
            expected_fields.push_back(r);
        endfunction

        function void check_beat(t_out got);
            t_out exp;
            if (expected_fields.size() == 0) begin
                $error("unexpected result beat: kind %0d value %0d", got.field_kind,
                       got.field_value);
                errors++;
                return;
            end
            exp = expected_fields.pop_front();
            if (got.field_kind !== exp.field_kind) begin
                $error("field_kind: expected %0d, got %0d", exp.field_kind, got.field_kind);
                errors++;
            end
            if (got.field_value !== exp.field_value) begin
                $error("field_value: expected %0d, got %0d", exp.field_value, got.field_value);
                errors++;
            end
            if (got.finished !== exp.finished) begin
                $error("finished: expected %0d, got %0d", exp.finished, got.finished);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    request_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int bytes_sent;

    camera_request_parser_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_in);
            if (o_out_valid && i_out_ready) sb.check_beat(o_out);
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // valid stays up between back-to-back beats
    task automatic send_byte(input logic [7:0] data, input logic last);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_in.byte_in   <= data;
        i_in.last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] frame[$]);
        for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_fields.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_length();
        return ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
    endfunction

    task automatic send_random_request();
        logic [7:0]  frame[$];
        logic [31:0] value;
        int          pick;
        int          len;
        int          pos;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 14)) frame.push_back(8'($urandom));
        end else begin
            frame = '{MAGIC_0, MAGIC_1, VERSION_OK};
            for (int i = 0; i < 7; i++) begin
                case ($urandom_range(7))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    3:       value = 32'h0000_0000;
                    default: value = $urandom;
                endcase
                for (int k = 0; k < 4; k++) frame.push_back(value[8*k +: 8]);
            end
            repeat (2) begin
                len = pick_length();
                frame.push_back(8'(len));
                repeat (len) frame.push_back(8'($urandom));
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
            end
            if (pick < 16) begin
                // corrupt magic or version
                pos = $urandom_range(2);
                frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
            end else if (pick < 34) begin
                pos   = $urandom_range(1, frame.size() - 1);
                frame = frame[0:pos-1];
            end
        end
        send_frame(frame);
    endtask

    initial begin
        logic [7:0] frame[$];
        sb = new();
        sb.clear();
        in_idle_pct  = 38;
        out_idle_pct = 64;
        bytes_sent   = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone bytes: short beats; then bad magic and bad version
        frame = '{MAGIC_0};
        send_frame(frame);
        frame = '{8'h00};
        send_frame(frame);
        frame = '{MAGIC_0, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h55, 8'hAA, 8'h00, 8'hFF};
        send_frame(frame);
        frame = '{MAGIC_0, MAGIC_1, 8'h00, MAGIC_0, MAGIC_1, VERSION_OK, 8'hFF, 8'h00,
                  8'h12, 8'h34};
        send_frame(frame);
        pause_until_drained();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    in_idle_pct  = 38;
                    out_idle_pct = 64;
                end
                1: begin
                    in_idle_pct  = 64;
                    out_idle_pct = 38;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            while (bytes_sent < 22 + (p + 1) * 217) send_random_request();
            pause_until_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.expected_fields.size() != 0) begin
            $error("%0d expected result beats never arrived", sb.expected_fields.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
